@@ design/mtrg_pkg.sv @@
// shared types and constants for the ranged twister generator
package mtrg_pkg;
   localparam int unsigned StateWords = 624;
   localparam int unsigned MiddleOffset = 397;
   localparam int unsigned IdxW = 10;
   localparam logic [31:0] InitMult = 32'd1812433253;
   localparam logic [31:0] TemperB = 32'd2636928640;
   localparam logic [31:0] TemperC = 32'd4022730752;
   localparam logic [31:0] TwistXor = 32'h9908b0df;
   localparam logic [31:0] UpperMask = 32'h80000000;
   localparam logic [31:0] LowerMask = 32'h7fffffff;
   localparam int unsigned QueueDepth = 2;

   typedef enum logic [1:0] {
      KIND_RAW   = 2'd0,
      KIND_BELOW = 2'd1,
      KIND_RANGE = 2'd2,
      KIND_BOOL  = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic        draw;
      logic [31:0] offset;
      logic [31:0] divisor;
   } job_type;

   function automatic logic [31:0] temper(input logic [31:0] x);
      logic [31:0] y;
      y = x ^ (x >> 11);
      y = y ^ ((y << 7) & TemperB);
      y = y ^ ((y << 15) & TemperC);
      y = y ^ (y >> 18);
      return y;
   endfunction
endpackage

@@ design/mtrg_ram.sv @@
// generic simple dual-port ram (one write port, one read port) with registered read
module mtrg_ram #(
   parameter int unsigned Width = 32,
   parameter int unsigned Depth = 624
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(Depth)-1:0] wr_addr,
   input  logic [Width-1:0]         wr_data,
   input  logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0]         rd_data
);
   logic [Width-1:0] mem [Depth];
   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

@@ design/mtrg_front.sv @@
// request classifier and job queue
module mtrg_front import mtrg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        take,
   input  logic [1:0]  kind,
   input  logic [31:0] low_bound,
   input  logic [31:0] high_bound,
   output logic        full,
   output logic        job_valid,
   output job_type     job,
   input  logic        job_pop
);
   localparam int unsigned PtrW = $clog2(QueueDepth);
   job_type           q_ff [QueueDepth];
   logic [PtrW-1:0]   wp_ff, rp_ff;
   logic [PtrW:0]     cnt_ff;
   job_type           j_in;
   logic              pos, nonempty;

   always_comb begin
      pos = !high_bound[31] && (high_bound != 32'd0);
      nonempty = $signed(high_bound) > $signed(low_bound);
      j_in.kind = kind_type'(kind);
      j_in.draw = 1'b1;
      j_in.offset = 32'd0;
      j_in.divisor = high_bound;
      unique case (kind_type'(kind))
         KIND_RAW, KIND_BOOL: ;
         KIND_BELOW: j_in.draw = pos;
         KIND_RANGE: begin
            j_in.draw = nonempty;
            j_in.offset = low_bound;
            j_in.divisor = high_bound - low_bound;
         end
         default: ;
      endcase
   end

   assign full = cnt_ff == (PtrW+1)'(QueueDepth);
   assign job_valid = cnt_ff != '0;
   assign job = q_ff[rp_ff];

   always_ff @(posedge clock) begin
      if (take) q_ff[wp_ff] <= j_in;
      if (reset) begin
         wp_ff <= '0;
         rp_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (take) wp_ff <= wp_ff + 1'b1;
         if (job_pop) rp_ff <= rp_ff + 1'b1;
         cnt_ff <= cnt_ff + (PtrW+1)'(take) - (PtrW+1)'(job_pop);
      end
   end
endmodule

@@ design/mtrg_back.sv @@
// state table sequencer, tempering and remainder unit
module mtrg_back import mtrg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write,
   input  logic [31:0] csr_seed_value,
   input  logic        job_valid,
   input  job_type     job,
   output logic        job_pop,
   output logic        rsp_valid,
   output logic [31:0] rsp_raw_word,
   output logic        rsp_drew,
   output logic [31:0] rsp_ranged_value
);
   typedef enum logic [3:0] {
      S_SEED, S_FILL_MUL, S_FILL_WR, S_IDLE, S_TW_RD0, S_TW_RD1, S_TW_RD2, S_TW_WR,
      S_RD, S_RD_WAIT, S_DIV, S_OUT
   } state_type;

   state_type     st_ff;
   logic [31:0]   seed_ff;
   logic [IdxW-1:0] k_ff, pos_ff;
   logic [31:0]   prev_ff, a_ff, b_ff, word_ff, rem_ff, quo_ff;
   logic [5:0]    bit_ff;
   job_type       job_ff;
   logic          we;
   logic [IdxW-1:0] wa, ra;
   logic [31:0]   wd, rd;
   logic [31:0]   mix, tw;
   logic [32:0]   trial;
   logic [IdxW-1:0] k1, km;

   mtrg_ram #(.Width(32), .Depth(StateWords)) u_ram (
      .clock(clock), .wr_en(we), .wr_addr(wa), .wr_data(wd), .rd_addr(ra), .rd_data(rd)
   );

   assign k1 = (k_ff == IdxW'(StateWords - 1)) ? '0 : k_ff + 1'b1;
   assign km = (k_ff >= IdxW'(StateWords - MiddleOffset)) ?
               k_ff - IdxW'(StateWords - MiddleOffset) : k_ff + IdxW'(MiddleOffset);
   assign mix = (a_ff & UpperMask) | (b_ff & LowerMask);
   assign tw = rd ^ (mix >> 1) ^ (mix[0] ? TwistXor : 32'd0);
   assign trial = {rem_ff, quo_ff[31]} - {1'b0, job_ff.divisor};

   always_comb begin
      we = 1'b0;
      wa = k_ff;
      wd = prev_ff;
      ra = k_ff;
      unique case (st_ff)
         S_SEED: begin we = 1'b1; wa = '0; wd = seed_ff; end
         S_FILL_WR: we = 1'b1;
         S_TW_RD0: ra = k_ff;
         S_TW_RD1: ra = k1;
         S_TW_RD2: ra = km;
         S_TW_WR: begin we = 1'b1; wd = tw; end
         S_RD: ra = pos_ff;
         default: ;
      endcase
   end

   assign job_pop = (st_ff == S_IDLE) && job_valid && !csr_write;

   always_ff @(posedge clock) begin
      rsp_valid <= 1'b0;
      if (csr_write) seed_ff <= csr_seed_value;
      if (reset) begin
         st_ff <= S_SEED;
         seed_ff <= 32'd5489;
      end else if (csr_write) begin
         st_ff <= S_SEED;
      end else begin
         unique case (st_ff)
            S_SEED: begin
               prev_ff <= seed_ff;
               k_ff <= IdxW'(1);
               st_ff <= S_FILL_MUL;
            end
            S_FILL_MUL: begin
               prev_ff <= InitMult * (prev_ff ^ (prev_ff >> 30)) + 32'(k_ff);
               st_ff <= S_FILL_WR;
            end
            S_FILL_WR: begin
               if (k_ff == IdxW'(StateWords - 1)) begin
                  pos_ff <= IdxW'(StateWords);
                  st_ff <= S_IDLE;
               end else begin
                  k_ff <= k_ff + 1'b1;
                  st_ff <= S_FILL_MUL;
               end
            end
            S_IDLE: if (job_valid) begin
               job_ff <= job;
               if (!job.draw) begin
                  rsp_valid <= 1'b1;
                  rsp_raw_word <= 32'd0;
                  rsp_drew <= 1'b0;
                  rsp_ranged_value <= job.offset;
               end else if (pos_ff >= IdxW'(StateWords)) begin
                  k_ff <= '0;
                  st_ff <= S_TW_RD0;
               end else st_ff <= S_RD;
            end
            S_TW_RD0: st_ff <= S_TW_RD1;
            S_TW_RD1: begin a_ff <= rd; st_ff <= S_TW_RD2; end
            S_TW_RD2: begin b_ff <= rd; st_ff <= S_TW_WR; end
            S_TW_WR: begin
               if (k_ff == IdxW'(StateWords - 1)) begin
                  pos_ff <= '0;
                  st_ff <= S_RD;
               end else begin
                  k_ff <= k_ff + 1'b1;
                  st_ff <= S_TW_RD0;
               end
            end
            S_RD: st_ff <= S_RD_WAIT;
            S_RD_WAIT: begin
               word_ff <= temper(rd);
               quo_ff <= temper(rd);
               rem_ff <= '0;
               bit_ff <= '0;
               pos_ff <= pos_ff + 1'b1;
               if (job_ff.kind == KIND_BELOW || job_ff.kind == KIND_RANGE) st_ff <= S_DIV;
               else st_ff <= S_OUT;
            end
            S_DIV: begin
               if (!trial[32]) rem_ff <= trial[31:0];
               else rem_ff <= {rem_ff[30:0], quo_ff[31]};
               quo_ff <= {quo_ff[30:0], 1'b0};
               bit_ff <= bit_ff + 1'b1;
               if (bit_ff == 6'd31) st_ff <= S_OUT;
            end
            S_OUT: begin
               rsp_valid <= 1'b1;
               rsp_raw_word <= word_ff;
               rsp_drew <= 1'b1;
               unique case (job_ff.kind)
                  KIND_RAW: rsp_ranged_value <= 32'd0;
                  KIND_BOOL: rsp_ranged_value <= {31'd0, word_ff[0]};
                  default: rsp_ranged_value <= job_ff.offset + rem_ff;
               endcase
               st_ff <= S_IDLE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ design/mt19937_ranged_generator_core.sv @@
// top level of the ranged twister generator
// A bounded or range draw runs the 32-step radix-2 remainder unit, which raw and
// boolean draws skip. The first draw after a fill and every 624th draw after it
// first regenerate the table, reading and rewriting it word by word. After reset
// and after each seed write the table is filled word by word before items are
// served; busy is high while the job queue is full.
// A result appears for one cycle on rsp_valid and cannot be held off.
module mt19937_ranged_generator_core import mtrg_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_kind,
   input  logic [31:0] req_low_bound,
   input  logic [31:0] req_high_bound,
   input  logic        csr_write,
   input  logic [31:0] csr_seed_value,
   output logic        rsp_valid,
   output logic [31:0] rsp_raw_word,
   output logic        rsp_drew,
   output logic [31:0] rsp_ranged_value
);
   logic    full, job_valid, job_pop;
   job_type job;

   assign busy = full;

   mtrg_front u_front (
      .clock(clock), .reset(reset), .take(start && !busy), .kind(req_kind),
      .low_bound(req_low_bound), .high_bound(req_high_bound), .full(full),
      .job_valid(job_valid), .job(job), .job_pop(job_pop)
   );

   mtrg_back u_back (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_seed_value(csr_seed_value),
      .job_valid(job_valid), .job(job), .job_pop(job_pop),
      .rsp_valid(rsp_valid), .rsp_raw_word(rsp_raw_word), .rsp_drew(rsp_drew),
      .rsp_ranged_value(rsp_ranged_value)
   );
endmodule

@@ design/mtrg_checker.sv @@
// port-level checks for the ranged twister generator
module mtrg_checker (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_drew,
   input logic [31:0] rsp_raw_word,
   input logic [31:0] rsp_ranged_value
);
   a_nodraw_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_drew |-> rsp_raw_word == 32'd0) else $error("raw word without draw");
   a_rsp_known: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$isunknown({rsp_drew, rsp_raw_word, rsp_ranged_value}))
      else $error("unknown result fields");
   a_no_rsp_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("item after reset");
   a_ready_after_reset: assert property (@(posedge clock)
      reset |=> !busy) else $error("busy after reset");
endmodule

bind mt19937_ranged_generator_core mtrg_checker u_checker (
   .clock(clock), .reset(reset), .busy(busy), .rsp_valid(rsp_valid), .rsp_drew(rsp_drew),
   .rsp_raw_word(rsp_raw_word), .rsp_ranged_value(rsp_ranged_value)
);

@@ bench/mt19937_ranged_generator_core_test.sv @@
// self-checking testbench for the ranged twister generator core
module mt19937_ranged_generator_core_test;
   import mtrg_pkg::*;

   typedef struct {
      logic [31:0] raw_word;
      logic        drew;
      logic [31:0] ranged_value;
   } outcome_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_kind;
   logic [31:0] req_low_bound;
   logic [31:0] req_high_bound;
   logic        csr_write;
   logic [31:0] csr_seed_value;
   logic        rsp_valid;
   logic [31:0] rsp_raw_word;
   logic        rsp_drew;
   logic [31:0] rsp_ranged_value;

   logic [31:0] mt_table [StateWords];
   int unsigned mt_pos;
   outcome_type pending_outcomes [$];
   int          failures;
   int          quiet_cycles;
   bit          gaps_on;

   mt19937_ranged_generator_core uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_low_bound(req_low_bound),
      .req_high_bound(req_high_bound), .csr_write(csr_write),
      .csr_seed_value(csr_seed_value), .rsp_valid(rsp_valid),
      .rsp_raw_word(rsp_raw_word), .rsp_drew(rsp_drew),
      .rsp_ranged_value(rsp_ranged_value)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic void seed_table(input logic [31:0] s);
      logic [31:0] p;
      mt_table[0] = s;
      for (int k = 1; k < StateWords; k++) begin
         p = mt_table[k - 1];
         mt_table[k] = InitMult * (p ^ (p >> 30)) + k;
      end
      mt_pos = StateWords;
   endfunction

   function automatic logic [31:0] next_word();
      logic [31:0] mix, v, y;
      if (mt_pos >= StateWords) begin
         for (int k = 0; k < StateWords; k++) begin
            mix = (mt_table[k] & UpperMask) | (mt_table[(k + 1) % StateWords] & LowerMask);
            v = mt_table[(k + MiddleOffset) % StateWords] ^ (mix >> 1);
            if (mix[0]) v = v ^ TwistXor;
            mt_table[k] = v;
         end
         mt_pos = 0;
      end
      y = mt_table[mt_pos];
      y = y ^ (y >> 11);
      y = y ^ ((y << 7) & TemperB);
      y = y ^ ((y << 15) & TemperC);
      y = y ^ (y >> 18);
      mt_pos++;
      return y;
   endfunction

   function automatic outcome_type predict_draw(input kind_type k, input logic [31:0] lo,
                                                input logic [31:0] hi);
      outcome_type o;
      o = '{32'd0, 1'b0, 32'd0};
      case (k)
         KIND_RAW: begin
            o.raw_word = next_word();
            o.drew = 1'b1;
         end
         KIND_BELOW: begin
            if ($signed(hi) > 0) begin
               o.raw_word = next_word();
               o.drew = 1'b1;
               o.ranged_value = o.raw_word % hi;
            end
         end
         KIND_RANGE: begin
            if ($signed(hi) > $signed(lo)) begin
               o.raw_word = next_word();
               o.drew = 1'b1;
               o.ranged_value = lo + (o.raw_word % (hi - lo));
            end else begin
               o.ranged_value = lo;
            end
         end
         default: begin
            o.raw_word = next_word();
            o.drew = 1'b1;
            o.ranged_value = {31'd0, o.raw_word[0]};
         end
      endcase
      return o;
   endfunction

   task automatic idle_gap();
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic send_item(input kind_type k, input logic [31:0] lo, input logic [31:0] hi);
      idle_gap();
      start <= 1'b1;
      req_kind <= k;
      req_low_bound <= lo;
      req_high_bound <= hi;
      @(posedge clock);
      while (busy) @(posedge clock);
      pending_outcomes.push_back(predict_draw(k, lo, hi));
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic write_seed(input logic [31:0] s);
      drain();
      csr_write <= 1'b1;
      csr_seed_value <= s;
      @(posedge clock);
      csr_write <= 1'b0;
      seed_table(s);
   endtask

   task automatic test_directed();
      send_item(KIND_RAW, 32'd0, 32'd0);
      send_item(KIND_BELOW, 32'd0, 32'd0);
      send_item(KIND_BELOW, 32'd5, 32'h8000_0000);
      send_item(KIND_BELOW, 32'hffff_ffff, 32'h7fff_ffff);
      send_item(KIND_BELOW, 32'd0, 32'd1);
      send_item(KIND_BELOW, 32'd0, 32'hffff_ffff);
      send_item(KIND_RANGE, 32'd7, 32'd7);
      send_item(KIND_RANGE, 32'd9, 32'd3);
      send_item(KIND_RANGE, 32'h8000_0000, 32'h7fff_ffff);
      send_item(KIND_RANGE, 32'h7fff_ffff, 32'h8000_0000);
      send_item(KIND_RANGE, 32'hffff_fff0, 32'd16);
      send_item(KIND_RANGE, 32'd100, 32'd101);
      send_item(KIND_BOOL, 32'hffff_ffff, 32'hffff_ffff);
      send_item(KIND_BOOL, 32'd0, 32'd0);
   endtask

   task automatic test_random(input int count);
      logic [31:0] lo, hi;
      for (int n = 0; n < count; n++) begin
         lo = $urandom();
         hi = $urandom();
         if ($urandom_range(0, 2) == 0) begin
            lo = $signed($urandom_range(0, 2000)) - 1000;
            hi = $signed($urandom_range(0, 2000)) - 1000;
         end
         send_item(kind_type'($urandom_range(0, 3)), lo, hi);
      end
   endtask

   task automatic test_wraparound();
      // enough raw draws to cross the table regeneration
      for (int n = 0; n < 700; n++) send_item(KIND_RAW, $urandom(), $urandom());
   endtask

   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid) begin
         if (pending_outcomes.size() == 0) begin
            $error("result with nothing pending");
            failures++;
         end else begin
            e = pending_outcomes.pop_front();
            if (rsp_raw_word !== e.raw_word) begin
               $error("raw_word expected %h actual %h", e.raw_word, rsp_raw_word);
               failures++;
            end
            if (rsp_drew !== e.drew) begin
               $error("drew expected %b actual %b", e.drew, rsp_drew);
               failures++;
            end
            if (rsp_ranged_value !== e.ranged_value) begin
               $error("ranged_value expected %h actual %h", e.ranged_value,
                      rsp_ranged_value);
               failures++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy) || csr_write) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > 40000) begin
         $display("mt19937_ranged_generator_core_test NOT OK");
         $finish;
      end
   end

   initial begin
      failures = 0;
      quiet_cycles = 0;
      gaps_on = 1'b1;
      reset = 1'b1;
      start = 1'b0;
      req_kind = KIND_RAW;
      req_low_bound = '0;
      req_high_bound = '0;
      csr_write = 1'b0;
      csr_seed_value = '0;
      seed_table(32'd5489);
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(300);
      write_seed(32'd0);
      test_random(150);
      write_seed(32'hffff_ffff);
      test_wraparound();
      write_seed($urandom());
      test_random(200);
      gaps_on = 1'b0;
      test_random(200);
      drain();
      if (failures == 0)
         $display("mt19937_ranged_generator_core_test OK");
      else
         $display("mt19937_ranged_generator_core_test NOT OK");
      $finish;
   end
endmodule
